[hdl/blz_pkg.sv]
// shared types and constants of the backward lz decoder
package blz_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 24;
  localparam int DIST_W   = 13;
  localparam int COUNT_W  = 5;
  localparam int TOKENS_W = 4;

  localparam logic [COUNT_W-1:0]  LEN_BIAS   = COUNT_W'(3);
  localparam logic [DIST_W-1:0]   DIST_BIAS  = DIST_W'(3);
  localparam logic [TOKENS_W-1:0] FLAG_TOKENS = TOKENS_W'(8);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH2
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_PRIME,
    SQ_COPY
  } seq_t;

endpackage

[hdl/blz_ram.sv]
// generic single write port ram with registered read
module blz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/backward_lz_decompressor_top.sv]
// backward lz77 decoder top level: token parser, copy sequencer and history ram
//
// Takes the compressed body one byte per request, last byte first, and emits the
// decoded bytes in reverse order. Every request, whether a flag byte, a literal,
// a match byte or any byte after the body, needs the output register free. The
// second byte of a match starts a copy of length 3 to 18 that holds the input:
// the SQ_PRIME state primes the history ram read, then one byte leaves per
// cycle while the output is not stalled, since the ram reads the next source
// slot while the current byte is written back. Output stall holds the copy.
// History is a ring of WINDOW_DEPTH bytes in one ram and is not cleared after
// reset.
module backward_lz_decompressor_top #(
  parameter int WINDOW_DEPTH = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [blz_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [blz_pkg::BYTE_W-1:0] comp_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [blz_pkg::BYTE_W-1:0] out_byte,
  output logic                       run_end,
  output logic                       stream_end
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

  logic [blz_pkg::LEN_W-1:0]    body_length;
  logic [blz_pkg::LEN_W-1:0]    consumed;
  logic                         finished;
  blz_pkg::phase_t              phase;
  logic [blz_pkg::BYTE_W-1:0]   flag_bits;
  logic [blz_pkg::TOKENS_W-1:0] tokens_left;
  logic [blz_pkg::BYTE_W-1:0]   match_high;
  logic [AW-1:0]                wp;
  logic [blz_pkg::COUNT_W-1:0]  count;
  logic [blz_pkg::DIST_W-1:0]   match_dist;
  logic                         last_fin;
  blz_pkg::seq_t                seq, seq_next;

  logic                         in_fire, active, fin_now, slot_free;
  logic                         lit_fire, match_fire, copy_fire, token_end;
  logic [blz_pkg::LEN_W-1:0]    consumed_inc;
  logic [AW-1:0]                wp_inc, base;
  logic [AW:0]                  base_x, dist_x, src_x;
  logic [AW-1:0]                rd_addr;
  logic [blz_pkg::BYTE_W-1:0]   rd_data, wr_data;
  logic                         wr_en;
  logic [blz_pkg::TOKENS_W-1:0] tokens_dec;

  assign slot_free    = !out_valid || !out_stall;
  assign in_stall     = (seq != blz_pkg::SQ_IDLE) || !slot_free;
  assign in_fire      = in_valid && !in_stall;
  assign active       = !finished && (consumed < body_length);
  assign consumed_inc = consumed + blz_pkg::LEN_W'(1);
  assign fin_now      = consumed_inc >= body_length;
  assign lit_fire     = in_fire && active && (phase == blz_pkg::PH_TOKEN) && !flag_bits[7];
  assign match_fire   = in_fire && active && (phase == blz_pkg::PH_MATCH2);
  assign copy_fire    = (seq == blz_pkg::SQ_COPY) && slot_free;
  assign token_end    = lit_fire || match_fire;
  assign tokens_dec   = (tokens_left != '0) ? tokens_left - blz_pkg::TOKENS_W'(1) : tokens_left;

  // ring arithmetic for the copy source slot
  assign wp_inc  = (wp == LAST_SLOT) ? '0 : wp + AW'(1);
  assign base    = copy_fire ? wp_inc : wp;
  assign base_x  = {1'b0, base};
  assign dist_x  = (AW+1)'(match_dist);
  assign src_x   = (base_x >= dist_x) ? base_x - dist_x : base_x + DEPTH_X - dist_x;
  assign rd_addr = src_x[AW-1:0];

  assign wr_en   = lit_fire || copy_fire;
  assign wr_data = lit_fire ? comp_byte : rd_data;

  blz_ram #(
    .WIDTH(blz_pkg::BYTE_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_history (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wp),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= blz_pkg::SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      blz_pkg::SQ_IDLE: begin
        if (match_fire) begin
          seq_next = blz_pkg::SQ_PRIME;
        end
      end
      blz_pkg::SQ_PRIME: seq_next = blz_pkg::SQ_COPY;
      blz_pkg::SQ_COPY: begin
        if (copy_fire && count == blz_pkg::COUNT_W'(1)) begin
          seq_next = blz_pkg::SQ_IDLE;
        end
      end
      default: seq_next = blz_pkg::SQ_IDLE;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      body_length <= '0;
      consumed    <= '0;
      finished    <= 1'b0;
      phase       <= blz_pkg::PH_FLAG;
      flag_bits   <= '0;
      tokens_left <= '0;
      match_high  <= '0;
      wp          <= '0;
    end else begin
      if (cfg_wr_en) begin
        body_length <= cfg_wr_data;
      end
      if (in_fire) begin
        if (!active) begin
          finished <= 1'b1;
        end else begin
          consumed <= consumed_inc;
          if (fin_now) begin
            finished <= 1'b1;
          end
          case (phase)
            blz_pkg::PH_FLAG: begin
              flag_bits   <= comp_byte;
              tokens_left <= blz_pkg::FLAG_TOKENS;
              phase       <= blz_pkg::PH_TOKEN;
            end
            blz_pkg::PH_TOKEN: begin
              if (flag_bits[7]) begin
                match_high <= comp_byte;
                phase      <= blz_pkg::PH_MATCH2;
              end
            end
            default: ;
          endcase
          if (token_end) begin
            flag_bits   <= {flag_bits[blz_pkg::BYTE_W-2:0], 1'b0};
            tokens_left <= tokens_dec;
            phase       <= (tokens_dec == '0) ? blz_pkg::PH_FLAG : blz_pkg::PH_TOKEN;
          end
        end
      end
      if (wr_en) begin
        wp <= wp_inc;
      end
    end
  end

  // copy run bookkeeping
  always_ff @(posedge clk) begin
    if (match_fire) begin
      count      <= blz_pkg::COUNT_W'(match_high[7:4]) + blz_pkg::LEN_BIAS;
      match_dist <= {match_high[3:0], comp_byte} + blz_pkg::DIST_BIAS;
      last_fin   <= fin_now;
    end else if (copy_fire) begin
      count <= count - blz_pkg::COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lit_fire) begin
      out_byte   <= comp_byte;
      run_end    <= 1'b1;
      stream_end <= fin_now;
    end else if (copy_fire) begin
      out_byte   <= rd_data;
      run_end    <= (count == blz_pkg::COUNT_W'(1));
      stream_end <= (count == blz_pkg::COUNT_W'(1)) && last_fin;
    end
  end

endmodule

[hdl/blz_checker.sv]
// port level checks for the backward lz decoder
module blz_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [blz_pkg::BYTE_W-1:0] out_byte,
  input logic                       run_end,
  input logic                       stream_end
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_end)
      && $stable(stream_end))
    else $error("stalled result changed");

  // last byte of the body closes its request's run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_end)
    else $error("stream end without run end");

  // nothing follows the end of the body
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && stream_end |=> !out_valid)
    else $error("result after stream end");

  // no request taken while a result is held up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while output stalled");

endmodule

bind backward_lz_decompressor_top blz_checker u_blz_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .run_end   (run_end),
  .stream_end(stream_end)
);
